### design/cge_pkg.sv
// Package of the central gravity Euler step block: widths, reset values,
// register indexes and iteration counts. No dependencies.
package cge_pkg;

  localparam int CoordW = 32;
  localparam int FracB = 20;
  localparam int RegW = 31;
  localparam int CfgIdxW = 2;
  localparam int CntW = 6;

  localparam logic [CfgIdxW-1:0] CfgMass = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStep = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinRadius = 2'd2;

  localparam logic [RegW-1:0] MassReset = 31'd4194304;
  localparam logic [RegW-1:0] StepReset = 31'd52429;
  localparam logic [RegW-1:0] MinRadiusReset = 31'd104858;
  localparam logic [CoordW-1:0] PosXReset = 32'd12582912;
  localparam logic [CoordW-1:0] VelYReset = 32'd608174;

  localparam logic [CoordW-1:0] CoordMax = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] CoordMin = 32'h8000_0000;
  localparam logic signed [63:0] CoordMax64 = 64'sd2147483647;
  localparam logic signed [63:0] CoordMin64 = -64'sd2147483648;

  // Last count value of each serial unit.
  localparam logic [CntW-1:0] MulLast = 6'd31;
  localparam logic [CntW-1:0] SqrtLast = 6'd31;
  localparam logic [CntW-1:0] DivLast = 6'd63;

endpackage

### design/central_gravity_euler_step_top.sv
// Top level of the central gravity Euler step block: one body's position
// and velocity with bit-serial multiply, divide and square root units.
// Depends on cge_pkg.
//
// Usage: configuration writes (central mass, time step, minimum radius) go
// through cfg_we_i / cfg_addr_i / cfg_data_i and take effect at once; write
// them only while the block is idle. Input beats use in_valid_i / in_ready_o,
// result beats use out_valid_o / out_ready_i. Every input beat gives one
// result beat with the body state after the item.
// A load beat passes through the finish state into the result register. A
// step beat runs three squarings, a square root and two divisions for the
// force (one if the first saturates), then per axis one division and three
// multiplications. A step inside the minimum radius ends after the square
// root. The shared shift-add multiplier and the restoring divider handle one
// bit per cycle each; the block works on one beat at a time. At reset the
// body sits at (12, 0, 0) with velocity (0, 0.58, 0) and the registers hold
// 4.0, 0.05 and 0.1. A finished result waits in the output register while
// the receiver stalls, and a new beat may be accepted meanwhile; its result
// waits until the register is free.
module central_gravity_euler_step_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cge_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [cge_pkg::RegW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [cge_pkg::CoordW-1:0]  load_pos_x_i,
  input  logic [cge_pkg::CoordW-1:0]  load_pos_y_i,
  input  logic [cge_pkg::CoordW-1:0]  load_pos_z_i,
  input  logic [cge_pkg::CoordW-1:0]  load_vel_x_i,
  input  logic [cge_pkg::CoordW-1:0]  load_vel_y_i,
  input  logic [cge_pkg::CoordW-1:0]  load_vel_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cge_pkg::CoordW-1:0]  pos_x_o,
  output logic [cge_pkg::CoordW-1:0]  pos_y_o,
  output logic [cge_pkg::CoordW-1:0]  pos_z_o,
  output logic [cge_pkg::CoordW-1:0]  vel_x_o,
  output logic [cge_pkg::CoordW-1:0]  vel_y_o,
  output logic [cge_pkg::CoordW-1:0]  vel_z_o,
  output logic                        moved_o,
  output logic                        saturated_o
);
  import cge_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_MUL, ST_SQRT, ST_CHK, ST_DIV_T, ST_DIV_Q,
    ST_DIV_U, ST_MUL_A, ST_MUL_V, ST_MUL_P, ST_DONE
  } state_e;

  function automatic logic [CoordW-1:0] magn_f(logic [CoordW-1:0] x);
    logic [CoordW-1:0] res;
    res = x[CoordW-1] ? CoordW'(~x + 1'b1) : x;
    return res;
  endfunction

  // Returns the clip flag above the clipped coordinate.
  function automatic logic [CoordW:0] clip_f(logic signed [63:0] x);
    logic [CoordW:0] res;
    if (x > CoordMax64) begin
      res = {1'b1, CoordMax};
    end else if (x < CoordMin64) begin
      res = {1'b1, CoordMin};
    end else begin
      res = {1'b0, x[CoordW-1:0]};
    end
    return res;
  endfunction

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  logic [1:0]        k_q;
  logic [RegW-1:0]   mass_q, dt_q, rmin_q;
  logic [CoordW-1:0] pos_q [3];
  logic [CoordW-1:0] vel_q [3];
  logic [63:0]       rsq_q;
  logic [CoordW-1:0] r_q;
  logic [RegW-1:0]   f_q;
  logic              sat_q, moved_q;

  logic [63:0]       mul_acc_q, mul_a_q;
  logic [CoordW-1:0] mul_b_q;
  logic              mul_neg_q;
  logic [63:0]       div_dvd_q;
  logic [CoordW-1:0] div_rem_q;
  logic [63:0]       sq_n_q;
  logic [33:0]       sq_rem_q;

  logic              out_valid_q;
  logic [CoordW-1:0] opos_q [3];
  logic [CoordW-1:0] ovel_q [3];
  logic              omoved_q, osat_q;

  logic [63:0]        mul_acc_nx;
  logic signed [63:0] mul_val, mul_shr;
  logic [32:0]        div_sh;
  logic               div_ge;
  logic [CoordW-1:0]  div_rem_nx;
  logic [63:0]        div_dvd_nx;
  logic [35:0]        sq_sh, sq_trial;
  logic               sq_ge;
  logic [33:0]        sq_rem_nx;
  logic [CoordW-1:0]  root_nx;
  logic [CoordW-1:0]  pos_k, vel_k;
  logic signed [63:0] pos_ext, vel_ext;
  logic [CoordW:0]    a_clip, v_clip, p_clip;
  logic [CoordW-1:0]  mag_k;
  logic               in_acc;

  assign in_acc = in_valid_i && in_ready_o;
  assign pos_k = pos_q[k_q];
  assign vel_k = vel_q[k_q];
  assign pos_ext = {{(64-CoordW){pos_k[CoordW-1]}}, pos_k};
  assign vel_ext = {{(64-CoordW){vel_k[CoordW-1]}}, vel_k};

  // Serial units: one multiplier bit, one quotient bit, one root bit a cycle.
  always_comb begin
    mul_acc_nx = mul_acc_q + (mul_b_q[0] ? mul_a_q : 64'd0);
    mul_val = mul_neg_q ? -$signed(mul_acc_nx) : $signed(mul_acc_nx);
    mul_shr = mul_val >>> FracB;
    div_sh = {div_rem_q, div_dvd_q[63]};
    div_ge = div_sh >= {1'b0, r_q};
    div_rem_nx = div_ge ? CoordW'(div_sh - {1'b0, r_q}) : div_sh[CoordW-1:0];
    div_dvd_nx = {div_dvd_q[62:0], div_ge};
    sq_sh = {sq_rem_q, sq_n_q[63:62]};
    sq_trial = {2'b00, r_q, 2'b01};
    sq_ge = sq_sh >= sq_trial;
    sq_rem_nx = sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
    root_nx = {r_q[CoordW-2:0], sq_ge};
    a_clip = clip_f(mul_shr);
    v_clip = clip_f(vel_ext + mul_shr);
    p_clip = clip_f(pos_ext + mul_shr);
    mag_k = magn_f(pos_k);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      k_q <= '0;
      mass_q <= MassReset;
      dt_q <= StepReset;
      rmin_q <= MinRadiusReset;
      pos_q[0] <= PosXReset;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
      vel_q[0] <= '0;
      vel_q[1] <= VelYReset;
      vel_q[2] <= '0;
      sat_q <= 1'b0;
      moved_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgMass:      mass_q <= cfg_data_i;
          CfgStep:      dt_q <= cfg_data_i;
          CfgMinRadius: rmin_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
      mul_acc_q <= mul_acc_nx;
      mul_a_q <= {mul_a_q[62:0], 1'b0};
      mul_b_q <= {1'b0, mul_b_q[CoordW-1:1]};
      div_dvd_q <= div_dvd_nx;
      div_rem_q <= div_rem_nx;
      sq_n_q <= {sq_n_q[61:0], 2'b00};
      sq_rem_q <= sq_rem_nx;
      if (state_q == ST_SQRT) begin
        r_q <= root_nx;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            sat_q <= 1'b0;
            moved_q <= 1'b0;
            k_q <= '0;
            cnt_q <= '0;
            if (action_i) begin
              pos_q[0] <= load_pos_x_i;
              pos_q[1] <= load_pos_y_i;
              pos_q[2] <= load_pos_z_i;
              vel_q[0] <= load_vel_x_i;
              vel_q[1] <= load_vel_y_i;
              vel_q[2] <= load_vel_z_i;
              state_q <= ST_DONE;
            end else begin
              rsq_q <= '0;
              mul_acc_q <= '0;
              mul_a_q <= {32'd0, magn_f(pos_q[0])};
              mul_b_q <= magn_f(pos_q[0]);
              state_q <= ST_SQ_MUL;
            end
          end
        end
        ST_SQ_MUL: begin
          if (cnt_q == MulLast) begin
            cnt_q <= '0;
            if (k_q == 2'd2) begin
              sq_n_q <= rsq_q + mul_acc_nx;
              sq_rem_q <= '0;
              r_q <= '0;
              state_q <= ST_SQRT;
            end else begin
              rsq_q <= rsq_q + mul_acc_nx;
              mul_acc_q <= '0;
              mul_a_q <= {32'd0, magn_f(pos_q[k_q + 2'd1])};
              mul_b_q <= magn_f(pos_q[k_q + 2'd1]);
              k_q <= k_q + 2'd1;
            end
          end
        end
        ST_SQRT: begin
          if (cnt_q == SqrtLast) begin
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          k_q <= '0;
          cnt_q <= '0;
          if (r_q > {1'b0, rmin_q}) begin
            div_dvd_q <= {13'd0, mass_q, 20'd0};
            div_rem_q <= '0;
            state_q <= ST_DIV_T;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DIV_T: begin
          if (cnt_q == DivLast) begin
            cnt_q <= '0;
            div_rem_q <= '0;
            if (div_dvd_nx[63:43] != '0) begin
              f_q <= CoordMax[RegW-1:0];
              sat_q <= 1'b1;
              div_dvd_q <= {12'd0, mag_k, 20'd0};
              state_q <= ST_DIV_U;
            end else begin
              div_dvd_q <= {div_dvd_nx[43:0], 20'd0};
              state_q <= ST_DIV_Q;
            end
          end
        end
        ST_DIV_Q: begin
          if (cnt_q == DivLast) begin
            cnt_q <= '0;
            div_rem_q <= '0;
            if (div_dvd_nx[63:31] != '0) begin
              f_q <= CoordMax[RegW-1:0];
              sat_q <= 1'b1;
            end else begin
              f_q <= div_dvd_nx[RegW-1:0];
            end
            div_dvd_q <= {12'd0, mag_k, 20'd0};
            state_q <= ST_DIV_U;
          end
        end
        ST_DIV_U: begin
          if (cnt_q == DivLast) begin
            // The unit vector points toward the origin.
            cnt_q <= '0;
            mul_acc_q <= '0;
            mul_a_q <= {33'd0, f_q};
            mul_b_q <= div_dvd_nx[CoordW-1:0];
            mul_neg_q <= ~pos_k[CoordW-1];
            state_q <= ST_MUL_A;
          end
        end
        ST_MUL_A: begin
          if (cnt_q == MulLast) begin
            cnt_q <= '0;
            sat_q <= sat_q | a_clip[CoordW];
            mul_acc_q <= '0;
            mul_a_q <= {32'd0, magn_f(a_clip[CoordW-1:0])};
            mul_b_q <= {1'b0, dt_q};
            mul_neg_q <= a_clip[CoordW-1];
            state_q <= ST_MUL_V;
          end
        end
        ST_MUL_V: begin
          if (cnt_q == MulLast) begin
            cnt_q <= '0;
            sat_q <= sat_q | v_clip[CoordW];
            vel_q[k_q] <= v_clip[CoordW-1:0];
            mul_acc_q <= '0;
            mul_a_q <= {32'd0, magn_f(v_clip[CoordW-1:0])};
            mul_b_q <= {1'b0, dt_q};
            mul_neg_q <= v_clip[CoordW-1];
            state_q <= ST_MUL_P;
          end
        end
        ST_MUL_P: begin
          if (cnt_q == MulLast) begin
            cnt_q <= '0;
            sat_q <= sat_q | p_clip[CoordW];
            pos_q[k_q] <= p_clip[CoordW-1:0];
            if (k_q == 2'd2) begin
              moved_q <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              div_dvd_q <= {12'd0, magn_f(pos_q[k_q + 2'd1]), 20'd0};
              div_rem_q <= '0;
              k_q <= k_q + 2'd1;
              state_q <= ST_DIV_U;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result payload; it changes only when a finished result enters the output register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      opos_q <= pos_q;
      ovel_q <= vel_q;
      omoved_q <= moved_q;
      osat_q <= sat_q;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o = opos_q[0];
  assign pos_y_o = opos_q[1];
  assign pos_z_o = opos_q[2];
  assign vel_x_o = ovel_q[0];
  assign vel_y_o = ovel_q[1];
  assign vel_z_o = ovel_q[2];
  assign moved_o = omoved_q;
  assign saturated_o = osat_q;

`ifndef ASSERT_OFF
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i) |=> (state_q == ST_DONE))
    else $error("load beat did not go straight to the result");
  a_chk_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |-> (k_q == 2'd2))
    else $error("radius check before all three squares were summed");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result beat raised outside the finish state");
`endif

endmodule

### tb/sv/central_gravity_euler_step_top_test.sv
// Testbench of the central gravity Euler step block: drives load and step
// beats, predicts each result with a fixed-point body model in a scoreboard.
// Depends on cge_pkg and central_gravity_euler_step_top.
module central_gravity_euler_step_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cge_pkg::*;

  typedef logic [CoordW-1:0] vec3_t [3];

  typedef struct {
    logic [CoordW-1:0] pos [3];
    logic [CoordW-1:0] vel [3];
    logic              moved;
    logic              sat;
  } body_state_t;

  class body_scoreboard;
    logic [RegW-1:0] mass, dt, rmin;
    longint pos [3];
    longint vel [3];
    body_state_t expected_q [$];
    int errors, loads, steps, moves, sats;

    function new();
      mass = MassReset;
      dt = StepReset;
      rmin = MinRadiusReset;
      pos[0] = longint'($signed(PosXReset));
      pos[1] = 0;
      pos[2] = 0;
      vel[0] = 0;
      vel[1] = longint'($signed(VelYReset));
      vel[2] = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= root + b) begin
          n -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    function longint clamp(longint x, inout bit s);
      if (x > CoordMax64) begin
        s = 1;
        return CoordMax64;
      end
      if (x < CoordMin64) begin
        s = 1;
        return CoordMin64;
      end
      return x;
    endfunction

    // Predicts the body state after one accepted beat.
    function void note_beat(bit load, vec3_t lp, vec3_t lv);
      longint unsigned rsq, r, t, q, mg;
      longint f, u, a, p;
      bit s, mv;
      body_state_t e;
      s = 0;
      mv = 0;
      if (load) begin
        loads++;
        for (int i = 0; i < 3; i++) begin
          pos[i] = longint'($signed(lp[i]));
          vel[i] = longint'($signed(lv[i]));
        end
      end else begin
        steps++;
        rsq = 0;
        for (int i = 0; i < 3; i++) begin
          mg = pos[i] < 0 ? -pos[i] : pos[i];
          rsq += mg * mg;
        end
        r = int_sqrt(rsq);
        if (r > rmin) begin
          t = (longint'(mass) << FracB) / r;
          if (t >= (64'd1 << (63 - FracB))) begin
            f = CoordMax64;
            s = 1;
          end else begin
            q = (t << FracB) / r;
            if (q > CoordMax64) begin
              f = CoordMax64;
              s = 1;
            end else begin
              f = q;
            end
          end
          for (int i = 0; i < 3; i++) begin
            p = pos[i];
            mg = p < 0 ? -p : p;
            u = longint'((mg << FracB) / r);
            if (p >= 0) u = -u;
            a = clamp((f * u) >>> FracB, s);
            vel[i] = clamp(vel[i] + ((a * longint'(dt)) >>> FracB), s);
            pos[i] = clamp(p + ((vel[i] * longint'(dt)) >>> FracB), s);
          end
          mv = 1;
          moves++;
        end
      end
      if (s) sats++;
      for (int i = 0; i < 3; i++) begin
        e.pos[i] = pos[i][CoordW-1:0];
        e.vel[i] = vel[i][CoordW-1:0];
      end
      e.moved = mv;
      e.sat = s;
      expected_q.push_back(e);
    endfunction

    function void check_beat(body_state_t got);
      body_state_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.pos[i] !== e.pos[i]) begin
          $error("pos[%0d] expected %h actual %h", i, e.pos[i], got.pos[i]);
          errors++;
        end
        if (got.vel[i] !== e.vel[i]) begin
          $error("vel[%0d] expected %h actual %h", i, e.vel[i], got.vel[i]);
          errors++;
        end
      end
      if (got.moved !== e.moved) begin
        $error("moved expected %b actual %b", e.moved, got.moved);
        errors++;
      end
      if (got.sat !== e.sat) begin
        $error("saturated expected %b actual %b", e.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr_i = CfgMass;
  logic [RegW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic action_i = 1'b0;
  logic [CoordW-1:0] load_pos_x_i = '0, load_pos_y_i = '0, load_pos_z_i = '0;
  logic [CoordW-1:0] load_vel_x_i = '0, load_vel_y_i = '0, load_vel_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CoordW-1:0] pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o;
  logic moved_o, saturated_o;

  body_scoreboard sb = new();
  bit quiet = 0;
  int hold_req = 0;
  int hold_left = 0;
  int sent = 0;

  central_gravity_euler_step_top i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_req != 0) begin
        hold_left = 3000;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  always @(posedge clk_i) begin
    body_state_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.pos[0] = pos_x_o;
      got.pos[1] = pos_y_o;
      got.pos[2] = pos_z_o;
      got.vel[0] = vel_x_o;
      got.vel[1] = vel_y_o;
      got.vel[2] = vel_z_o;
      got.moved = moved_o;
      got.sat = saturated_o;
      sb.check_beat(got);
    end
  end

  task automatic send_beat(bit load, vec3_t lp, vec3_t lv);
    if (!quiet && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= load;
    load_pos_x_i <= lp[0];
    load_pos_y_i <= lp[1];
    load_pos_z_i <= lp[2];
    load_vel_x_i <= lv[0];
    load_vel_y_i <= lv[1];
    load_vel_z_i <= lv[2];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(load, lp, lv);
    sent++;
  endtask

  task automatic load_body(vec3_t lp, vec3_t lv);
    send_beat(1'b1, lp, lv);
  endtask

  task automatic step_body();
    vec3_t junk;
    for (int i = 0; i < 3; i++) junk[i] = $urandom;
    send_beat(1'b0, junk, junk);
  endtask

  // Drains all results, then writes the three registers.
  task automatic set_regs(logic [RegW-1:0] m, logic [RegW-1:0] d, logic [RegW-1:0] rm);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CfgMass;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_addr_i <= CfgStep;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_addr_i <= CfgMinRadius;
    cfg_data_i <= rm;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.mass = m;
    sb.dt = d;
    sb.rmin = rm;
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    logic [CoordW-1:0] x;
    x = $urandom;
    if ($urandom_range(0, 4) == 0) return x;
    return $signed(x) >>> $urandom_range(4, 12);
  endfunction

  initial begin
    vec3_t lp, lv;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: the reset orbit, the origin, the radius edge and extremes.
    repeat (3) step_body();
    load_body('{0, 0, 0}, '{32'h0010_0000, 0, 0});
    step_body();
    load_body('{32'd104858, 0, 0}, '{0, 0, 0});
    step_body();
    load_body('{32'd104859, 0, 0}, '{0, 0, 0});
    step_body();
    load_body('{CoordMax, CoordMax, CoordMax}, '{CoordMax, CoordMax, CoordMax});
    step_body();
    load_body('{CoordMin, CoordMin, CoordMin}, '{CoordMin, CoordMin, CoordMin});
    step_body();
    set_regs({RegW{1'b1}}, {RegW{1'b1}}, '0);
    load_body('{1, 0, 32'hFFFF_FFFF}, '{0, 0, 0});
    step_body();
    step_body();
    set_regs('0, '0, {RegW{1'b1}});
    load_body('{CoordMax, 0, 0}, '{CoordMin, 0, 0});
    step_body();
    set_regs(MassReset, StepReset, MinRadiusReset);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          set_regs(RegW'($urandom_range(1 << 18, 1 << 24)),
                   RegW'($urandom_range(1 << 12, 1 << 17)),
                   RegW'($urandom_range(0, 1 << 20)));
          hold_req = 1;
          for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 3; i++) begin
              lp[i] = $urandom;
              lv[i] = $urandom;
            end
            load_body(lp, lv);
          end
        end
        2: begin
          quiet = 1;
          set_regs(RegW'($urandom), RegW'($urandom), RegW'($urandom));
        end
        3: begin
          quiet = 0;
          set_regs({RegW{1'b1}}, RegW'($urandom_range(1 << 12, 1 << 17)), '0);
        end
        4: set_regs('0, {RegW{1'b1}}, RegW'($urandom_range(0, 1 << 20)));
        5: set_regs(RegW'($urandom_range(1 << 18, 1 << 24)), '0, {RegW{1'b1}});
        default: ;
      endcase
      while (sent < 20 + 100 * (ph + 1)) begin
        for (int i = 0; i < 3; i++) begin
          lp[i] = ($urandom_range(0, 99) < 80) ? rand_coord() : CoordW'($urandom);
          lv[i] = ($urandom_range(0, 99) < 80) ? rand_coord() : CoordW'($urandom);
        end
        if ($urandom_range(0, 99) < 80) begin
          load_body(lp, lv);
          repeat ($urandom_range(1, 3)) step_body();
        end else if ($urandom_range(0, 1) == 0) begin
          load_body(lp, lv);
        end else begin
          step_body();
        end
      end
    end

    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d loads and %0d steps (%0d moved, %0d saturated).",
             sb.loads, sb.steps, sb.moves, sb.sats);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
